@@ rtl/tsud_pkg.sv @@
// types, constants and codes shared by the screen-update decoder
// depends on nothing; every other file refers to it by scoped names
package tsud_pkg;

  // cap applied to the values of both cell-count registers where they are used
  localparam int unsigned MaxCells = 2048;

  localparam int unsigned WordW    = 16;
  localparam int unsigned ScreenW  = 14;
  localparam int unsigned CursorW  = 16;
  localparam int unsigned CountW   = 12;
  localparam int unsigned CellIdxW = 11;
  localparam int unsigned CellW    = 15;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned CfgIdxW  = 2;

  // reset values of the cell-count registers (50 x 30 and 40 x 30)
  localparam logic [CountW-1:0] TopCountReset    = CountW'(50 * 30);
  localparam logic [CountW-1:0] BottomCountReset = CountW'(40 * 30);

  // screen numbers with a meaning of their own
  localparam logic [ScreenW-1:0] ScreenTop    = ScreenW'(0);
  localparam logic [ScreenW-1:0] ScreenBottom = ScreenW'(1);
  localparam logic [ScreenW-1:0] ScreenKeys   = ScreenW'(2);
  localparam logic [ScreenW-1:0] ScreenTouch  = ScreenW'(3);

  // payload words still expected after a key or touch selection
  localparam logic [1:0] PendNone   = 2'd0;
  localparam logic [1:0] PendSecond = 2'd1;
  localparam logic [1:0] PendFirst  = 2'd2;

  typedef enum logic [1:0] {
    KindCell  = 2'd0,
    KindKey   = 2'd1,
    KindTouch = 2'd2
  } result_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegTopCount    = 2'd0,
    RegBottomCount = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             packet_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic                target_screen;
    logic [CellIdxW-1:0] cell_index;
    logic [CellW-1:0]    cell_word;
    logic [KeyW-1:0]     key_state;
    logic [WordW-1:0]    touch_x;
    logic [WordW-1:0]    touch_y;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CountW-1:0]  data;
  } cfg_write_t;

  // cell limits in use, handed from the register file to the decoder
  typedef struct packed {
    logic [CountW-1:0] top_count;
    logic [CountW-1:0] bottom_count;
  } cell_counts_t;

endpackage

@@ rtl/tsud_intf.sv @@
// valid/ready channel interfaces of the screen-update decoder
// depends on tsud_pkg for the payload types
interface tsud_in_if;
  logic               valid;
  logic               ready;
  tsud_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tsud_out_if;
  logic                valid;
  logic                ready;
  tsud_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tsud_cfg_if;
  logic                 valid;
  logic                 ready;
  tsud_pkg::cfg_write_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/tsud_cfg_regs.sv @@
// cell-count configuration registers of the screen-update decoder
// depends on tsud_pkg and the tsud_cfg_if interface
module tsud_cfg_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  tsud_cfg_if.sink                cfg_if,
  output tsud_pkg::cell_counts_t  counts_o
);

  logic [tsud_pkg::CountW-1:0] top_q, top_d;
  logic [tsud_pkg::CountW-1:0] bottom_q, bottom_d;
  logic                        wr_en;

  // writes are always taken
  assign cfg_if.ready = 1'b1;
  assign wr_en        = cfg_if.valid;

  // register decode, unknown indexes are ignored
  always_comb begin
    top_d    = top_q;
    bottom_d = bottom_q;
    if (wr_en) begin
      case (cfg_if.data.index)
        tsud_pkg::RegTopCount:    top_d    = cfg_if.data.data;
        tsud_pkg::RegBottomCount: bottom_d = cfg_if.data.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= tsud_pkg::TopCountReset;
      bottom_q <= tsud_pkg::BottomCountReset;
    end else begin
      top_q    <= top_d;
      bottom_q <= bottom_d;
    end
  end

  assign counts_o.top_count    = top_q;
  assign counts_o.bottom_count = bottom_q;

endmodule

@@ rtl/tsud_decoder.sv @@
// decode state and per-word decode logic of the screen-update decoder
// depends on tsud_pkg; fed by the input register, feeds tsud_out_reg
module tsud_decoder #(
  parameter int unsigned MaxCells = tsud_pkg::MaxCells
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  tsud_pkg::in_item_t     item_i,
  input  tsud_pkg::cell_counts_t counts_i,
  output logic                   res_valid_o,
  output tsud_pkg::out_item_t    res_o
);

  logic [tsud_pkg::ScreenW-1:0] screen_q, screen_d;
  logic [tsud_pkg::CursorW-1:0] cursor_q, cursor_d;
  logic [1:0]                   pend_q, pend_d;
  logic                         is_touch_q, is_touch_d;
  logic [tsud_pkg::WordW-1:0]   first_q, first_d;

  logic [tsud_pkg::ScreenW-1:0] screen_cur;
  logic [tsud_pkg::CursorW-1:0] cursor_cur;
  logic [1:0]                   pend_cur;
  logic [tsud_pkg::WordW-1:0]   w;
  logic [tsud_pkg::CountW-1:0]  count_sel;
  logic                         in_range;

  assign w = item_i.word;

  // packet start clears selection, cursor and any unfinished payload
  assign screen_cur = item_i.packet_start ? '0 : screen_q;
  assign cursor_cur = item_i.packet_start ? '0 : cursor_q;
  assign pend_cur   = item_i.packet_start ? tsud_pkg::PendNone : pend_q;

  // cursor below both the register value and the fixed cap
  assign count_sel = (screen_cur == tsud_pkg::ScreenTop) ? counts_i.top_count
                                                         : counts_i.bottom_count;
  assign in_range  = (cursor_cur < {{(tsud_pkg::CursorW-tsud_pkg::CountW){1'b0}}, count_sel})
                  && (cursor_cur < tsud_pkg::CursorW'(MaxCells));

  // word decode
  always_comb begin
    screen_d    = screen_cur;
    cursor_d    = cursor_cur;
    pend_d      = pend_cur;
    is_touch_d  = is_touch_q;
    first_d     = first_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (pend_cur == tsud_pkg::PendFirst) begin
      first_d = w;
      pend_d  = tsud_pkg::PendSecond;
    end else if (pend_cur == tsud_pkg::PendSecond) begin
      pend_d      = tsud_pkg::PendNone;
      res_valid_o = 1'b1;
      if (is_touch_q) begin
        res_o.result_kind = tsud_pkg::KindTouch;
        res_o.touch_x     = first_q;
        res_o.touch_y     = w;
      end else begin
        res_o.result_kind = tsud_pkg::KindKey;
        res_o.key_state   = {first_q, w};
      end
    end else if (w[15:14] == 2'b11) begin
      // screen selection
      screen_d = w[tsud_pkg::ScreenW-1:0];
      if (w[tsud_pkg::ScreenW-1:0] == tsud_pkg::ScreenKeys ||
          w[tsud_pkg::ScreenW-1:0] == tsud_pkg::ScreenTouch) begin
        pend_d     = tsud_pkg::PendFirst;
        is_touch_d = (w[tsud_pkg::ScreenW-1:0] == tsud_pkg::ScreenTouch);
      end else begin
        cursor_d = '0;
      end
    end else if (w[15]) begin
      // cursor jump
      cursor_d = {1'b0, w[14:0]};
    end else begin
      // cell write, the cursor advances even when the write is dropped
      if ((screen_cur == tsud_pkg::ScreenTop || screen_cur == tsud_pkg::ScreenBottom)
          && in_range) begin
        res_valid_o         = 1'b1;
        res_o.result_kind   = tsud_pkg::KindCell;
        res_o.target_screen = screen_cur[0];
        res_o.cell_index    = cursor_cur[tsud_pkg::CellIdxW-1:0];
        res_o.cell_word     = w[tsud_pkg::CellW-1:0];
      end
      cursor_d = cursor_cur + tsud_pkg::CursorW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_q   <= '0;
      cursor_q   <= '0;
      pend_q     <= tsud_pkg::PendNone;
      is_touch_q <= 1'b0;
      first_q    <= '0;
    end else if (step_i) begin
      screen_q   <= screen_d;
      cursor_q   <= cursor_d;
      pend_q     <= pend_d;
      is_touch_q <= is_touch_d;
      first_q    <= first_d;
    end
  end

endmodule

@@ rtl/tsud_out_reg.sv @@
// result register driving the output channel of the screen-update decoder
// depends on tsud_pkg and the tsud_out_if interface
module tsud_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  tsud_pkg::out_item_t data_i,
  output logic                free_o,
  tsud_out_if.source          out_if
);

  logic                valid_q, valid_d;
  tsud_pkg::out_item_t data_q;

  // register can take a new result when empty or being drained
  assign free_o = !valid_q || out_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= data_i;
    end
  end

  assign out_if.valid = valid_q;
  assign out_if.data  = data_q;

endmodule

@@ rtl/text_screen_update_decoder.sv @@
// top level of the screen-update packet decoder
// depends on tsud_pkg, tsud_intf, tsud_cfg_regs, tsud_decoder, tsud_out_reg
//
//  channel  dir  payload                                   transaction when
//  in_if    in   word, packet_start                        valid && ready
//  out_if   out  result_kind, target_screen, cell_index,   valid && ready
//                cell_word, key_state, touch_x, touch_y
//  cfg_if   in   index (0 top count, 1 bottom count), data valid && ready
//
// one word per cycle while the output is not stalled: a word is captured in
// the input register, decoded from there and its result, if any, lands in
// the output register. reset clears the decode state and sets the cell
// counts to 1500 and 1200. a stall on the output holds the result register
// and the input register, and input ready drops only while both are full.
module text_screen_update_decoder #(
  parameter int unsigned MaxCells = tsud_pkg::MaxCells
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsud_in_if.sink    in_if,
  tsud_out_if.source out_if,
  tsud_cfg_if.sink   cfg_if
);

  logic                   in_valid_q, in_valid_d;
  tsud_pkg::in_item_t     in_data_q;
  logic                   out_free;
  logic                   step;
  logic                   res_valid;
  tsud_pkg::out_item_t    res;
  tsud_pkg::cell_counts_t counts;

  // input register moves on whenever the result register has room
  assign step        = in_valid_q && out_free;
  assign in_if.ready = !in_valid_q || out_free;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_if.ready) begin
      in_valid_d = in_if.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_data_q <= in_if.data;
    end
  end

  tsud_cfg_regs u_cfg_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_if   (cfg_if),
    .counts_o (counts)
  );

  tsud_decoder #(
    .MaxCells (MaxCells)
  ) u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_data_q),
    .counts_i    (counts),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tsud_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step && res_valid),
    .data_i (res),
    .free_o (out_free),
    .out_if (out_if)
  );

endmodule

@@ dv/text_screen_update_decoder_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the screen-update packet decoder
// depends on tsud_pkg, the tsud_intf channel interfaces and the decoder rtl
module text_screen_update_decoder_tb;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned PhaseWords  = 180;
  localparam int unsigned LongHold    = 200;
  localparam int unsigned DrainCycles = 8;

  logic clk = 1'b0;
  logic rst_n;

  tsud_in_if  in_if ();
  tsud_out_if out_if ();
  tsud_cfg_if cfg_if ();

  text_screen_update_decoder DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // clock
  always #5 clk = ~clk;

  // words waiting to be sent and decoder updates waiting to come out
  tsud_pkg::in_item_t  word_queue[$];
  tsud_pkg::out_item_t expected_updates[$];

  // decoder state as the testbench sees it
  logic [tsud_pkg::ScreenW-1:0] scr_sel;
  logic [tsud_pkg::CursorW-1:0] cursor_pos;
  logic [1:0]                   payload_left;
  logic                         payload_touch;
  logic [tsud_pkg::WordW-1:0]   payload_hi;
  logic [tsud_pkg::CountW-1:0]  top_count;
  logic [tsud_pkg::CountW-1:0]  bottom_count;

  int unsigned errors;
  int unsigned words_accepted;
  int unsigned updates_checked;
  int unsigned settings_used;
  int unsigned idle_cycles;

  // sender and receiver pacing
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned pattern_age;
  int unsigned pattern_pos;
  logic [15:0] stall_pattern;
  bit          long_hold_armed;
  bit          long_hold_done;

  // limit in use: register value capped at the screen maximum
  function automatic int unsigned cell_cap(logic [tsud_pkg::CountW-1:0] count);
    return (count > tsud_pkg::MaxCells) ? tsud_pkg::MaxCells : int'(count);
  endfunction

  // append one expected update
  function automatic void expect_update(tsud_pkg::out_item_t upd);
    expected_updates = {expected_updates, upd};
  endfunction

  // advance the decoder state by one accepted word, queueing any update
  function automatic void decode_word(tsud_pkg::in_item_t it);
    tsud_pkg::out_item_t upd;
    logic [15:0]         w;
    int unsigned         lim;
    w   = it.word;
    upd = '0;
    if (it.packet_start) begin
      scr_sel      = tsud_pkg::ScreenTop;
      cursor_pos   = '0;
      payload_left = tsud_pkg::PendNone;
    end
    if (payload_left == tsud_pkg::PendFirst) begin
      payload_hi   = w;
      payload_left = tsud_pkg::PendSecond;
    end else if (payload_left == tsud_pkg::PendSecond) begin
      payload_left = tsud_pkg::PendNone;
      if (payload_touch) begin
        upd.result_kind = tsud_pkg::KindTouch;
        upd.touch_x     = payload_hi;
        upd.touch_y     = w;
      end else begin
        upd.result_kind = tsud_pkg::KindKey;
        upd.key_state   = {payload_hi, w};
      end
      expect_update(upd);
    end else if (w[15:14] == 2'b11) begin
      scr_sel = w[13:0];
      if (scr_sel == tsud_pkg::ScreenKeys || scr_sel == tsud_pkg::ScreenTouch) begin
        payload_left  = tsud_pkg::PendFirst;
        payload_touch = (scr_sel == tsud_pkg::ScreenTouch);
      end else begin
        cursor_pos = '0;
      end
    end else if (w[15]) begin
      cursor_pos = {1'b0, w[14:0]};
    end else begin
      if (scr_sel == tsud_pkg::ScreenTop || scr_sel == tsud_pkg::ScreenBottom) begin
        lim = cell_cap(scr_sel == tsud_pkg::ScreenTop ? top_count : bottom_count);
        if (cursor_pos < lim) begin
          upd.result_kind   = tsud_pkg::KindCell;
          upd.target_screen = scr_sel[0];
          upd.cell_index    = cursor_pos[tsud_pkg::CellIdxW-1:0];
          upd.cell_word     = w[14:0];
          expect_update(upd);
        end
      end
      cursor_pos = cursor_pos + 1'b1;
    end
  endfunction

  function automatic void mismatch_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 10)
        $display("mismatch on %0s: expected %0h, got %0h", name, exp_v, act_v);
    end
  endfunction

  function automatic void compare_update(tsud_pkg::out_item_t exp_u,
                                         tsud_pkg::out_item_t act_u);
    mismatch_field("result_kind", 32'(exp_u.result_kind), 32'(act_u.result_kind));
    mismatch_field("target_screen", 32'(exp_u.target_screen), 32'(act_u.target_screen));
    mismatch_field("cell_index", 32'(exp_u.cell_index), 32'(act_u.cell_index));
    mismatch_field("cell_word", 32'(exp_u.cell_word), 32'(act_u.cell_word));
    mismatch_field("key_state", exp_u.key_state, act_u.key_state);
    mismatch_field("touch_x", 32'(exp_u.touch_x), 32'(act_u.touch_x));
    mismatch_field("touch_y", 32'(exp_u.touch_y), 32'(act_u.touch_y));
  endfunction

  function automatic void push_word(logic [15:0] w, bit start);
    tsud_pkg::in_item_t it;
    it.word         = w;
    it.packet_start = start;
    word_queue = {word_queue, it};
  endfunction

  // cursor target for a jump: low, around a screen limit, or anywhere
  function automatic logic [13:0] jump_target();
    int lim;
    case ($urandom_range(0, 2))
      0: return 14'($urandom_range(0, 2100));
      1: begin
        lim = cell_cap($urandom_range(0, 1) ? top_count : bottom_count);
        lim = lim + $urandom_range(0, 6) - 3;
        return 14'((lim < 0) ? 0 : lim);
      end
      default: return 14'($urandom);
    endcase
  endfunction

  // one packet with random content, at times with its payload cut short; returns words pushed
  function automatic int unsigned gen_packet();
    int unsigned n_entries;
    int unsigned pushed;
    int unsigned pick;
    bit          start;
    n_entries = $urandom_range(1, 12);
    pushed    = 0;
    for (int e = 0; e < n_entries; e++) begin
      start = (e == 0);
      pick  = $urandom_range(0, 99);
      if (pick < 55) begin
        push_word({1'b0, 15'($urandom)}, start);
        pushed += 1;
      end else if (pick < 70) begin
        push_word({2'b10, jump_target()}, start);
        pushed += 1;
      end else if (pick < 82) begin
        push_word(16'hC000 | 16'($urandom_range(0, 1)), start);
        pushed += 1;
      end else if (pick < 94) begin
        push_word(16'hC000 | 16'($urandom_range(2, 3)), start);
        push_word(16'($urandom), 1'b0);
        push_word(16'($urandom), 1'b0);
        pushed += 3;
      end else if (pick < 97) begin
        push_word(16'hC000 | 16'($urandom_range(4, 16'h3FFF)), start);
        pushed += 1;
      end else begin
        // payload cut short by the next packet
        push_word(16'hC000 | 16'($urandom_range(2, 3)), start);
        pushed += 1;
        if ($urandom_range(0, 1)) begin
          push_word(16'($urandom), 1'b0);
          pushed += 1;
        end
        e = n_entries;
      end
    end
    return pushed;
  endfunction

  // mostly packets, some raw noise words
  function automatic void gen_random_words(int unsigned n);
    int unsigned made;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) == 0) begin
        push_word(16'($urandom), 1'($urandom));
        made += 1;
      end else begin
        made += gen_packet();
      end
    end
  endfunction

  // hold until every word is sent and every update has come out
  task automatic wait_idle();
    while (word_queue.size() != 0 || in_if.valid || expected_updates.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(tsud_pkg::cfg_reg_e idx, logic [tsud_pkg::CountW-1:0] val);
    tsud_pkg::cfg_write_t wr;
    wr.index = idx;
    wr.data  = val;
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= wr;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      tsud_pkg::RegTopCount:    top_count = val;
      tsud_pkg::RegBottomCount: bottom_count = val;
      default: ;
    endcase
  endtask

  task automatic set_counts(logic [tsud_pkg::CountW-1:0] top_v,
                            logic [tsud_pkg::CountW-1:0] bottom_v);
    wait_idle();
    write_reg(tsud_pkg::RegTopCount, top_v);
    write_reg(tsud_pkg::RegBottomCount, bottom_v);
    settings_used++;
  endtask

  // word driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_word(in_if.data);
        words_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (word_queue.size() != 0) begin
          in_if.valid <= 1'b1;
          in_if.data  <= word_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // update receiver: rolling stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (long_hold_armed && !long_hold_done) begin
        hold_left      = LongHold;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (pattern_age == 0) begin
          pattern_age = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0:       stall_pattern = 16'hFFFF;
            1:       stall_pattern = 16'($urandom);
            2:       stall_pattern = 16'($urandom) | 16'($urandom);
            default: stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
          endcase
        end
        pattern_age--;
        out_if.ready <= stall_pattern[pattern_pos];
        pattern_pos = (pattern_pos + 1) % 16;
      end
    end
  end

  // update monitor: check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_updates.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("update with nothing expected: %0h", out_if.data);
      end else begin
        compare_update(expected_updates.pop_front(), out_if.data);
        updates_checked++;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d cycles without a transaction", IdleLimit);
        $display("text_screen_update_decoder_tb NOT OK");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    scr_sel       = '0;
    cursor_pos    = '0;
    payload_left  = tsud_pkg::PendNone;
    payload_touch = 1'b0;
    payload_hi    = '0;
    top_count     = tsud_pkg::TopCountReset;
    bottom_count  = tsud_pkg::BottomCountReset;

    // directed words against the reset limits of 1500 and 1200
    push_word(16'h0000, 1'b1);
    push_word(16'h3FFF, 1'b0);
    push_word(16'h8000 | 16'd1499, 1'b0);
    push_word(16'h2AAA, 1'b0);            // last top cell
    push_word(16'h5555, 1'b0);            // one past the top limit
    push_word(16'hFFFF, 1'b0);            // unknown screen
    push_word(16'h1234, 1'b0);
    push_word(16'hC001, 1'b0);
    push_word(16'h8000 | 16'd1199, 1'b0);
    push_word(16'h0F0F, 1'b0);            // last bottom cell
    push_word(16'h7000, 1'b0);
    push_word(16'hC002, 1'b0);            // key state
    push_word(16'hFFFF, 1'b0);
    push_word(16'h0000, 1'b0);
    push_word(16'h0001, 1'b0);            // dropped while keys are selected
    push_word(16'hC003, 1'b0);            // touch, payload with top bits set
    push_word(16'hC000, 1'b0);
    push_word(16'h8001, 1'b0);
    push_word(16'hC002, 1'b0);            // payload cut by a new packet
    push_word(16'h1111, 1'b0);
    push_word(16'h0042, 1'b1);
    push_word(16'hBFFF, 1'b0);            // highest cursor jump
    push_word(16'h0000, 1'b0);
    push_word(16'h8000, 1'b1);
    push_word(16'h3000, 1'b0);
    push_word(16'hC000, 1'b0);
    push_word(16'h4321, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    settings_used = 1;

    // random phases over several limits, extremes among them
    set_counts(12'd4095, 12'd0);
    gen_random_words(PhaseWords);
    set_counts(12'd2048, 12'd2047);
    gen_random_words(PhaseWords);
    set_counts(12'd0, 12'd4095);
    gen_random_words(PhaseWords);
    set_counts(12'd37, 12'd64);
    gen_random_words(PhaseWords);
    long_hold_armed = 1'b1;
    set_counts(12'($urandom), 12'($urandom));
    gen_random_words(PhaseWords);

    while (word_queue.size() != 0 || in_if.valid || expected_updates.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (expected_updates.size() != 0) begin
      errors += expected_updates.size();
      $display("%0d expected updates never arrived", expected_updates.size());
    end

    $display("covered %0d words and %0d checked updates over %0d cell-count settings,",
             words_accepted, updates_checked, settings_used);
    $display("including payload cuts, limit edges and a long output stall");
    if (errors == 0) begin
      $display("text_screen_update_decoder_tb OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("text_screen_update_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule
